// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the grain translator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_AT(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, expr)

`endif

`endif

// ===== sv/sdgt_pkg.sv =====
// Types, constants and helpers shared by the grain translator modules.
`timescale 1ns / 1ps

package sdgt_pkg;

   // Metadata store geometry
   localparam int META_WORDS      = 16384;
   localparam int META_AW         = 14;
   localparam int WORDS_PER_BLOCK = 128;
   localparam int WPB_LOG2        = 7;
   localparam int BLK_FIELD_W     = META_AW - WPB_LOG2;

   // Front-to-back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int ENTRY_ADDR_W = 41;

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_BAD   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_LOADED    = 3'd0,
      ST_READ_ZERO = 3'd1,
      ST_MAPPED    = 3'd2,
      ST_SKIPPED   = 3'd3,
      ST_ALLOCATED = 3'd4,
      ST_RANGE     = 3'd5
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRAIN_LOG2 = 3'd0,
      CSR_TABLE_LOG2 = 3'd1,
      CSR_PRIM_DIR   = 3'd2,
      CSR_RED_DIR    = 3'd3,
      CSR_RED_EN     = 3'd4,
      CSR_FIRST_FREE = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_REJECT = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      BK_IDLE = 3'd0,
      BK_DIR  = 3'd1,
      BK_TAB  = 3'd2,
      BK_RDIR = 3'd3,
      BK_WR2  = 3'd4
   } back_state_type;

   typedef struct packed {
      logic [4:0] grain_log2;
      logic [4:0] table_log2;
      logic [6:0] prim_dir;
      logic [6:0] red_dir;
      logic       red_en;
   } cfg_type;

   // One classified item as it travels from front to back
   typedef struct packed {
      op_type             op;
      logic               is_write;
      logic               all_zero;
      logic               pdir_oob;
      logic               rdir_oob;
      logic [META_AW-1:0] pdir_addr;
      logic [META_AW-1:0] rdir_addr;
      logic [31:0]        gt_index;
      logic [31:0]        goff;
      logic [META_AW-1:0] meta_addr;
      logic [31:0]        meta_word;
   } job_type;

   typedef struct packed {
      status_type              status;
      logic [31:0]             phys;
      logic [31:0]             new_grain;
      logic [ENTRY_ADDR_W-1:0] prim_addr;
      logic [ENTRY_ADDR_W-1:0] red_addr;
      logic                    red_write;
   } rsp_type;

   typedef struct packed {
      logic               oob;
      logic [META_AW-1:0] addr;
   } addr_chk_type;

   // Word address blk * WORDS_PER_BLOCK + idx, flagged when beyond the store
   function automatic addr_chk_type block_addr(input logic [31:0] blk,
                                               input logic [31:0] idx);
      logic [META_AW:0] sum;
      addr_chk_type     r;
      sum = {1'b0, blk[BLK_FIELD_W-1:0], {WPB_LOG2{1'b0}}} + {1'b0, idx[META_AW-1:0]};
      r.oob  = (|blk[31:BLK_FIELD_W]) | (|idx[31:META_AW]) | sum[META_AW];
      r.addr = sum[META_AW-1:0];
      return r;
   endfunction

endpackage

// ===== sv/sdgt_front.sv =====
// Front end: accepts items and classifies them into jobs for the back end.
`timescale 1ns / 1ps

module sdgt_front (
   input  sdgt_pkg::cfg_type  cfg,
   input  logic [1:0]         req_kind,
   input  logic [31:0]        req_block_index,
   input  logic [13:0]        req_meta_addr,
   input  logic [31:0]        req_meta_word,
   input  logic               req_block_all_zero,
   output sdgt_pkg::job_type  job
);

   logic [5:0]               split_shift;
   logic [31:0]              dir_index;
   logic [31:0]              tab_mask;
   logic [31:0]              off_mask;
   sdgt_pkg::addr_chk_type   pdir_chk;
   sdgt_pkg::addr_chk_type   rdir_chk;
   sdgt_pkg::kind_type       kind;

   // Split the block index into directory, table and offset parts
   assign split_shift = {1'b0, cfg.grain_log2} + {1'b0, cfg.table_log2};
   assign dir_index   = req_block_index >> split_shift;
   assign tab_mask    = ~(32'hFFFF_FFFF << cfg.table_log2);
   assign off_mask    = ~(32'hFFFF_FFFF << cfg.grain_log2);
   assign pdir_chk    = sdgt_pkg::block_addr(32'(cfg.prim_dir), dir_index);
   assign rdir_chk    = sdgt_pkg::block_addr(32'(cfg.red_dir), dir_index);
   assign kind        = sdgt_pkg::kind_type'(req_kind);

   // Classify
   always_comb begin
      job.is_write  = (kind == sdgt_pkg::KIND_WRITE);
      job.all_zero  = req_block_all_zero;
      job.pdir_oob  = pdir_chk.oob;
      job.rdir_oob  = rdir_chk.oob;
      job.pdir_addr = pdir_chk.addr;
      job.rdir_addr = rdir_chk.addr;
      job.gt_index  = (req_block_index >> cfg.grain_log2) & tab_mask;
      job.goff      = req_block_index & off_mask;
      job.meta_addr = req_meta_addr;
      job.meta_word = req_meta_word;
      unique case (kind)
         sdgt_pkg::KIND_LOAD: begin
            if (32'(req_meta_addr) >= sdgt_pkg::META_WORDS) begin
               job.op = sdgt_pkg::OP_REJECT;
            end else begin
               job.op = sdgt_pkg::OP_LOAD;
            end
         end
         sdgt_pkg::KIND_READ, sdgt_pkg::KIND_WRITE: begin
            job.op = sdgt_pkg::OP_LOOKUP;
         end
         default: begin
            job.op = sdgt_pkg::OP_REJECT;
         end
      endcase
   end

endmodule

// ===== sv/sdgt_queue.sv =====
// Short job queue between the front and back ends.
`timescale 1ns / 1ps

module sdgt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sdgt_pkg::job_type  push_job,
   input  logic               pop,
   output sdgt_pkg::job_type  head_job,
   output logic               head_valid,
   output logic               full
);

   sdgt_pkg::job_type                  slot_ff [sdgt_pkg::QUEUE_DEPTH];
   logic [sdgt_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [sdgt_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [sdgt_pkg::QCNT_W-1:0]        count_ff, count_in;

   assign head_job   = slot_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == sdgt_pkg::QCNT_W'(sdgt_pkg::QUEUE_DEPTH));

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/sdgt_back.sv =====
// Back end: metadata store, lookup sequencer, allocation and result register.
`timescale 1ns / 1ps

module sdgt_back (
   input  logic               clock,
   input  logic               reset,
   input  sdgt_pkg::cfg_type  cfg,
   input  logic               nfb_load,
   input  logic [31:0]        nfb_value,
   input  sdgt_pkg::job_type  head_job,
   input  logic               head_valid,
   output logic               pop,
   output logic               rsp_valid,
   output sdgt_pkg::rsp_type  rsp
);

   logic [31:0]                    meta_mem [sdgt_pkg::META_WORDS];
   logic [31:0]                    mem_rd_ff;
   logic                           mem_we;
   logic [sdgt_pkg::META_AW-1:0]   mem_addr;

   sdgt_pkg::back_state_type       state_ff, state_in;
   sdgt_pkg::job_type              job_ff;
   logic [sdgt_pkg::META_AW-1:0]   ptab_ff, ptab_in;
   logic [sdgt_pkg::META_AW-1:0]   rtab_ff, rtab_in;
   logic                           rdir_hit_ff, rdir_hit_in;
   logic [31:0]                    nfb_ff;
   logic                           bump;
   logic                           rsp_valid_ff, rsp_fire;
   sdgt_pkg::rsp_type              rsp_ff, rsp_in;

   sdgt_pkg::addr_chk_type         tab_chk;
   sdgt_pkg::addr_chk_type         rtab_chk;
   logic [31:0]                    rdent;

   assign tab_chk  = sdgt_pkg::block_addr(mem_rd_ff, job_ff.gt_index);
   assign rdent    = rdir_hit_ff ? nfb_ff : mem_rd_ff;
   assign rtab_chk = sdgt_pkg::block_addr(rdent, job_ff.gt_index);

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Metadata store, single port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         meta_mem[mem_addr] <= (state_ff == sdgt_pkg::BK_IDLE) ? head_job.meta_word : nfb_ff;
      end
      mem_rd_ff <= meta_mem[mem_addr];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sdgt_pkg::BK_IDLE: begin
            if (head_valid && head_job.op == sdgt_pkg::OP_LOOKUP && !head_job.pdir_oob) begin
               state_in = sdgt_pkg::BK_DIR;
            end
         end
         sdgt_pkg::BK_DIR: begin
            state_in = tab_chk.oob ? sdgt_pkg::BK_IDLE : sdgt_pkg::BK_TAB;
         end
         sdgt_pkg::BK_TAB: begin
            if (mem_rd_ff <= 32'd1 && job_ff.is_write && !job_ff.all_zero &&
                cfg.red_en && !job_ff.rdir_oob) begin
               state_in = sdgt_pkg::BK_RDIR;
            end else begin
               state_in = sdgt_pkg::BK_IDLE;
            end
         end
         sdgt_pkg::BK_RDIR: begin
            state_in = rtab_chk.oob ? sdgt_pkg::BK_IDLE : sdgt_pkg::BK_WR2;
         end
         sdgt_pkg::BK_WR2: begin
            state_in = sdgt_pkg::BK_IDLE;
         end
         default: begin
            state_in = sdgt_pkg::BK_IDLE;
         end
      endcase
   end

   // Outputs: memory port, queue pop, result and allocation
   always_comb begin
      mem_we      = 1'b0;
      mem_addr    = '0;
      pop         = 1'b0;
      rsp_fire    = 1'b0;
      rsp_in      = '0;
      bump        = 1'b0;
      ptab_in     = ptab_ff;
      rtab_in     = rtab_ff;
      rdir_hit_in = rdir_hit_ff;
      unique case (state_ff)
         sdgt_pkg::BK_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               unique case (head_job.op)
                  sdgt_pkg::OP_LOAD: begin
                     mem_we        = 1'b1;
                     mem_addr      = head_job.meta_addr;
                     rsp_fire      = 1'b1;
                     rsp_in.status = sdgt_pkg::ST_LOADED;
                  end
                  sdgt_pkg::OP_LOOKUP: begin
                     mem_addr = head_job.pdir_addr;
                     if (head_job.pdir_oob) begin
                        rsp_fire      = 1'b1;
                        rsp_in.status = sdgt_pkg::ST_RANGE;
                     end
                  end
                  default: begin
                     rsp_fire      = 1'b1;
                     rsp_in.status = sdgt_pkg::ST_RANGE;
                  end
               endcase
            end
         end
         sdgt_pkg::BK_DIR: begin
            // Directory entry in hand: fetch the table entry
            mem_addr = tab_chk.addr;
            ptab_in  = tab_chk.addr;
            if (tab_chk.oob) begin
               rsp_fire      = 1'b1;
               rsp_in.status = sdgt_pkg::ST_RANGE;
            end
         end
         sdgt_pkg::BK_TAB: begin
            if (mem_rd_ff > 32'd1) begin
               rsp_fire      = 1'b1;
               rsp_in.status = sdgt_pkg::ST_MAPPED;
               rsp_in.phys   = mem_rd_ff + job_ff.goff;
            end else if (!job_ff.is_write) begin
               rsp_fire      = 1'b1;
               rsp_in.status = sdgt_pkg::ST_READ_ZERO;
            end else if (job_ff.all_zero) begin
               rsp_fire      = 1'b1;
               rsp_in.status = sdgt_pkg::ST_SKIPPED;
            end else if (!cfg.red_en) begin
               // Allocate: primary entry only
               mem_we           = 1'b1;
               mem_addr         = ptab_ff;
               bump             = 1'b1;
               rsp_fire         = 1'b1;
               rsp_in.status    = sdgt_pkg::ST_ALLOCATED;
               rsp_in.phys      = nfb_ff + job_ff.goff;
               rsp_in.new_grain = nfb_ff;
               rsp_in.prim_addr = sdgt_pkg::ENTRY_ADDR_W'({ptab_ff, 2'b00});
            end else if (job_ff.rdir_oob) begin
               rsp_fire      = 1'b1;
               rsp_in.status = sdgt_pkg::ST_RANGE;
            end else begin
               // Redundant directory word; it sees the primary update when it overlaps
               mem_addr    = job_ff.rdir_addr;
               rdir_hit_in = (job_ff.rdir_addr == ptab_ff);
            end
         end
         sdgt_pkg::BK_RDIR: begin
            if (rtab_chk.oob) begin
               rsp_fire      = 1'b1;
               rsp_in.status = sdgt_pkg::ST_RANGE;
            end else begin
               mem_we   = 1'b1;
               mem_addr = ptab_ff;
               rtab_in  = rtab_chk.addr;
            end
         end
         sdgt_pkg::BK_WR2: begin
            mem_we           = 1'b1;
            mem_addr         = rtab_ff;
            bump             = 1'b1;
            rsp_fire         = 1'b1;
            rsp_in.status    = sdgt_pkg::ST_ALLOCATED;
            rsp_in.phys      = nfb_ff + job_ff.goff;
            rsp_in.new_grain = nfb_ff;
            rsp_in.prim_addr = sdgt_pkg::ENTRY_ADDR_W'({ptab_ff, 2'b00});
            rsp_in.red_addr  = sdgt_pkg::ENTRY_ADDR_W'({rtab_ff, 2'b00});
            rsp_in.red_write = 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdgt_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
         nfb_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_fire;
         if (nfb_load) begin
            nfb_ff <= nfb_value;
         end else if (bump) begin
            nfb_ff <= nfb_ff + (32'd1 << cfg.grain_log2);
         end
      end
   end

   // Working payload
   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= head_job;
      end
      ptab_ff     <= ptab_in;
      rtab_ff     <= rtab_in;
      rdir_hit_ff <= rdir_hit_in;
      rsp_ff      <= rsp_in;
   end

endmodule

// ===== sv/sparse_disk_grain_translator.sv =====
// Top level of the sparse disk grain translator: registers, front, queue, back.
//
//   channel   ports              handshake
//   request   start/busy, req_*  taken when start high and busy low
//   result    rsp_strobe, rsp_*  valid for one cycle, no backpressure
//   config    csr_we/index/wdata written at any edge with csr_we high
//
// Loads, rejects and lookups with an out-of-range directory word are answered
// from the idle state; other lookups read the directory word, then the table
// word; plain allocations write the primary entry. Redundant allocations also
// read the redundant directory word, then write both entries (or report out of
// range on a bad redundant table word); the single metadata RAM port serves
// each dependent read and write in turn. A two-entry queue takes items while
// the back end works; busy is high while it is full. Reset initialises control
// and config; the metadata store is not cleared and holds garbage until loaded.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sparse_disk_grain_translator (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_kind,
   input  logic [31:0]  req_block_index,
   input  logic [13:0]  req_meta_addr,
   input  logic [31:0]  req_meta_word,
   input  logic         req_block_all_zero,
   output logic         rsp_strobe,
   output logic [2:0]   rsp_status,
   output logic [31:0]  rsp_physical_block,
   output logic [31:0]  rsp_new_grain_block,
   output logic [40:0]  rsp_primary_entry_addr,
   output logic [40:0]  rsp_redundant_entry_addr,
   output logic         rsp_redundant_write,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   sdgt_pkg::cfg_type   cfg_ff;
   sdgt_pkg::job_type   front_job;
   sdgt_pkg::job_type   head_job;
   sdgt_pkg::rsp_type   rsp;
   logic                head_valid;
   logic                queue_full;
   logic                pop;
   logic                push;
   logic                nfb_load;
   logic                rsp_alloc;
   logic                rsp_addr_seen;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grain_log2 <= 5'd7;
         cfg_ff.table_log2 <= 5'd9;
         cfg_ff.prim_dir   <= '0;
         cfg_ff.red_dir    <= '0;
         cfg_ff.red_en     <= 1'b0;
      end else if (csr_we) begin
         case (sdgt_pkg::csr_index_type'(csr_index))
            sdgt_pkg::CSR_GRAIN_LOG2: cfg_ff.grain_log2 <= csr_wdata[4:0];
            sdgt_pkg::CSR_TABLE_LOG2: cfg_ff.table_log2 <= csr_wdata[4:0];
            sdgt_pkg::CSR_PRIM_DIR:   cfg_ff.prim_dir   <= csr_wdata[6:0];
            sdgt_pkg::CSR_RED_DIR:    cfg_ff.red_dir    <= csr_wdata[6:0];
            sdgt_pkg::CSR_RED_EN:     cfg_ff.red_en     <= csr_wdata[0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign nfb_load = csr_we && (csr_index == sdgt_pkg::CSR_FIRST_FREE);
   assign push     = start && !queue_full;
   assign busy     = queue_full;

   sdgt_front u_front (
      .cfg                (cfg_ff),
      .req_kind           (req_kind),
      .req_block_index    (req_block_index),
      .req_meta_addr      (req_meta_addr),
      .req_meta_word      (req_meta_word),
      .req_block_all_zero (req_block_all_zero),
      .job                (front_job)
   );

   sdgt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (front_job),
      .pop        (pop),
      .head_job   (head_job),
      .head_valid (head_valid),
      .full       (queue_full)
   );

   sdgt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .nfb_load   (nfb_load),
      .nfb_value  (csr_wdata),
      .head_job   (head_job),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_valid  (rsp_strobe),
      .rsp        (rsp)
   );

   assign rsp_status               = rsp.status;
   assign rsp_physical_block       = rsp.phys;
   assign rsp_new_grain_block      = rsp.new_grain;
   assign rsp_primary_entry_addr   = rsp.prim_addr;
   assign rsp_redundant_entry_addr = rsp.red_addr;
   assign rsp_redundant_write      = rsp.red_write;

   // Result classification for the checks below
   assign rsp_alloc     = (rsp_status == sdgt_pkg::ST_ALLOCATED);
   assign rsp_addr_seen = (rsp_primary_entry_addr != '0) || (rsp_new_grain_block != '0);

   // Redundant update is flagged only on an allocation
   `ASSERT_AT(a_red_only_alloc, clock, reset, rsp_strobe && rsp_redundant_write |-> rsp_alloc)
   // An allocation flags the redundant update exactly when it is enabled
   `ASSERT_AT(a_red_en, clock, reset, rsp_strobe && rsp_alloc |-> rsp.red_write == cfg_ff.red_en)
   // Items other than allocations report no entry addresses
   `ASSERT_NEVER(a_no_addr_leak, clock, reset, rsp_strobe && !rsp_alloc && rsp_addr_seen)
   // The back end never pops an empty queue
   `ASSERT_NEVER(a_no_empty_pop, clock, reset, pop && !head_valid)

endmodule
